/* sv/jsu_pkg.sv */
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int PKT_BYTES = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } scan_mode_t;

  // One input byte's worth of results, handed from the front end to the back end.
  typedef struct packed {
    logic [PKT_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      fin;
  } jsu_pkt_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [15:0] CP_MAX1 = 16'h007F;
  localparam logic [15:0] CP_MAX2 = 16'h07FF;
  localparam logic [7:0]  LEAD2   = 8'hC0;
  localparam logic [7:0]  LEAD3   = 8'hE0;
  localparam logic [7:0]  CONT    = 8'h80;

endpackage

/* sv/jsu_in_if.sv */
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

/* sv/jsu_out_if.sv */
`timescale 1ns / 1ps

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_done;

  modport source (output valid, out_byte, byte_valid, run_last, string_done, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, string_done, output ready);
endinterface

/* sv/json_string_unescape.sv */
`timescale 1ns / 1ps

// Channel      Direction  Payload
// in_stream    sink       in_byte[7:0], final_byte
// out_stream   source     out_byte[7:0], byte_valid, run_last, string_done
//
// The front end decodes one input byte per cycle while the packet queue is not full
// into a packet of up to five output bytes; the back end sends one output byte per
// cycle while out_stream.ready is high, so an input byte that expands into k results
// holds the back end for k transfers. Packets pass the queue, then the output stage.
// in_stream.ready drops only while the packet queue is full.
// Reset is synchronous and clears the scan state, the queue and the output stage.

module json_string_unescape
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_stream,
  jsu_out_if.source out_stream
);

  logic     push;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  jsu_pkt_t push_pkt;
  jsu_pkt_t q_pkt;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_stream(in_stream),
    .q_full   (q_full),
    .push     (push),
    .push_pkt (push_pkt)
  );

  jsu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (pop),
    .pop_pkt  (q_pkt),
    .not_empty(q_valid)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pkt     (q_pkt),
    .pop       (pop),
    .out_stream(out_stream)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("packet written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("packet taken from an empty queue");

  a_marker_ends_string: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && !out_stream.byte_valid |-> out_stream.string_done)
    else $error("end marker outside the end of a string");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_stream.valid)
    else $error("output valid straight after reset");
`endif

endmodule

/* sv/jsu_front.sv */
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  jsu_in_if.sink   in_stream,
  input  logic     q_full,
  output logic     push,
  output jsu_pkt_t push_pkt
);

  scan_mode_t  mode, mode_next;
  logic [1:0]  dc, dc_next;
  logic [15:0] cp, cp_next;
  logic [7:0]  hd [3];
  logic [7:0]  hd_next [3];

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_shift;
  logic [2:0]  n;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign b        = in_stream.in_byte;
  assign fin      = in_stream.final_byte;
  assign cp_shift = {cp[11:0], hex_val};
  assign in_stream.ready = !q_full;
  assign accept   = in_stream.valid && !q_full;

  always_comb begin
    push_pkt  = '0;
    n         = 3'd0;
    mode_next = mode;
    dc_next   = dc;
    cp_next   = cp;
    hd_next   = hd;

    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        case (b)
          CH_B: begin push_pkt.bytes[n] = CTL_BS; n = n + 3'd1; end
          CH_F: begin push_pkt.bytes[n] = CTL_FF; n = n + 3'd1; end
          CH_N: begin push_pkt.bytes[n] = CTL_LF; n = n + 3'd1; end
          CH_R: begin push_pkt.bytes[n] = CTL_CR; n = n + 3'd1; end
          CH_T: begin push_pkt.bytes[n] = CTL_HT; n = n + 3'd1; end
          CH_U: begin
            mode_next = MODE_HEX;
            dc_next   = 2'd0;
            cp_next   = 16'd0;
          end
          default: begin push_pkt.bytes[n] = b; n = n + 3'd1; end
        endcase
      end
      MODE_HEX: begin
        if (!hex_ok) begin
          // Give up on the escape: emit the marker and the digits, then rescan.
          push_pkt.bytes[n] = CH_QMARK;
          n = n + 3'd1;
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < dc) begin
              push_pkt.bytes[n] = hd[i];
              n = n + 3'd1;
            end
          end
          mode_next = MODE_PLAIN;
          dc_next   = 2'd0;
          cp_next   = 16'd0;
          if (b == CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            push_pkt.bytes[n] = b;
            n = n + 3'd1;
          end
        end else if (dc == 2'd3) begin
          if (cp_shift <= CP_MAX1) begin
            push_pkt.bytes[0] = cp_shift[7:0];
            n = 3'd1;
          end else if (cp_shift <= CP_MAX2) begin
            push_pkt.bytes[0] = LEAD2 | {3'b000, cp_shift[10:6]};
            push_pkt.bytes[1] = CONT | {2'b00, cp_shift[5:0]};
            n = 3'd2;
          end else begin
            push_pkt.bytes[0] = LEAD3 | {4'b0000, cp_shift[15:12]};
            push_pkt.bytes[1] = CONT | {2'b00, cp_shift[11:6]};
            push_pkt.bytes[2] = CONT | {2'b00, cp_shift[5:0]};
            n = 3'd3;
          end
          mode_next = MODE_PLAIN;
          dc_next   = 2'd0;
          cp_next   = 16'd0;
        end else begin
          hd_next[dc] = b;
          dc_next     = dc + 2'd1;
          cp_next     = cp_shift;
        end
      end
      default: begin
        if (b == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          push_pkt.bytes[n] = b;
          n = n + 3'd1;
        end
      end
    endcase

    // On the final byte, clear the scan state; inside a unicode escape, flush what was collected.
    if (fin) begin
      if (mode_next == MODE_HEX) begin
        push_pkt.bytes[n] = CH_QMARK;
        n = n + 3'd1;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < dc_next) begin
            push_pkt.bytes[n] = hd_next[i];
            n = n + 3'd1;
          end
        end
      end
      mode_next = MODE_PLAIN;
      dc_next   = 2'd0;
      cp_next   = 16'd0;
    end

    push_pkt.count = n;
    push_pkt.fin   = fin;
  end

  assign push = accept && (n != 3'd0 || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      dc   <= 2'd0;
      cp   <= 16'd0;
    end else if (accept) begin
      mode <= mode_next;
      dc   <= dc_next;
      cp   <= cp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hd <= hd_next;
    end
  end

endmodule

/* sv/jsu_queue.sv */
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  jsu_pkt_t push_pkt,
  output logic     full,
  input  logic     pop,
  output jsu_pkt_t pop_pkt,
  output logic     not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  jsu_pkt_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_FULL);
  assign not_empty = (fill != '0);
  assign pop_pkt   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/jsu_back.sv */
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  jsu_pkt_t q_pkt,
  output logic     pop,
  jsu_out_if.source out_stream
);

  logic       busy;
  jsu_pkt_t   cur;
  logic [2:0] idx;
  logic       last;
  logic       xfer;

  // A packet with no bytes is the end marker of a string.
  assign last = (cur.count == 3'd0) || (idx == cur.count - 3'd1);
  assign xfer = busy && out_stream.ready;
  assign pop  = q_valid && (!busy || (xfer && last));

  assign out_stream.valid       = busy;
  assign out_stream.out_byte    = (cur.count == 3'd0) ? 8'h00 : cur.bytes[idx];
  assign out_stream.byte_valid  = (cur.count != 3'd0);
  assign out_stream.run_last    = last;
  assign out_stream.string_done = last && cur.fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
      end
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_pkt;
    end
  end

endmodule

/* tb/sv/json_string_unescape_tb.sv */
`timescale 1ns / 1ps

module json_string_unescape_tb
  import jsu_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 6;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_UPPER = 8'h41;
  localparam logic [7:0] CHR_LOWER = 8'h61;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
  } unesc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  always #10 clk = ~clk;

  // Decoder state as seen by the predictor.
  scan_mode_t    esc_mode;
  logic [1:0]    digits_held;
  logic [7:0]    digit_store [3];
  logic [15:0]   code_acc;

  logic [7:0]    decoded_q [$];
  unesc_result_t expected_q [$];
  logic [7:0]    text_q [$];
  unesc_result_t head_r;

  int            errors = 0;
  int            bytes_sent = 0;
  int            cycle_cnt = 0;
  bit            tx_gaps = 1'b0;
  bit            rx_gaps = 1'b0;
  int            rx_hold_len = 0;

  function automatic int hex_value(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void emit_utf8(logic [15:0] cp);
    if (cp <= CP_MAX1) begin
      decoded_q.push_back(cp[7:0]);
    end else if (cp <= CP_MAX2) begin
      decoded_q.push_back(LEAD2 | {3'b000, cp[10:6]});
      decoded_q.push_back(CONT | {2'b00, cp[5:0]});
    end else begin
      decoded_q.push_back(LEAD3 | {4'b0000, cp[15:12]});
      decoded_q.push_back(CONT | {2'b00, cp[11:6]});
      decoded_q.push_back(CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void clear_unicode();
    esc_mode    = MODE_PLAIN;
    digits_held = 2'd0;
    code_acc    = 16'h0000;
  endfunction

  // A broken \u sequence gives a question mark and then the digits taken so far.
  function automatic void flush_unicode();
    decoded_q.push_back(CH_QMARK);
    for (int i = 0; i < digits_held; i++) decoded_q.push_back(digit_store[i]);
    clear_unicode();
  endfunction

  function automatic void decode_plain(logic [7:0] b);
    if (b == CH_BSLASH) esc_mode = MODE_ESC;
    else decoded_q.push_back(b);
  endfunction

  function automatic void predict_unescape(logic [7:0] b, logic fin);
    int h;
    int n;
    decoded_q.delete();
    case (esc_mode)
      MODE_ESC: begin
        esc_mode = MODE_PLAIN;
        case (b)
          CH_B: decoded_q.push_back(CTL_BS);
          CH_F: decoded_q.push_back(CTL_FF);
          CH_N: decoded_q.push_back(CTL_LF);
          CH_R: decoded_q.push_back(CTL_CR);
          CH_T: decoded_q.push_back(CTL_HT);
          CH_U: begin
            esc_mode    = MODE_HEX;
            digits_held = 2'd0;
            code_acc    = 16'h0000;
          end
          default: decoded_q.push_back(b);
        endcase
      end
      MODE_HEX: begin
        h = hex_value(b);
        if (h < 0) begin
          flush_unicode();
          decode_plain(b);
        end else begin
          code_acc = {code_acc[11:0], h[3:0]};
          if (digits_held == 2'd3) begin
            emit_utf8(code_acc);
            clear_unicode();
          end else begin
            digit_store[digits_held] = b;
            digits_held++;
          end
        end
      end
      default: decode_plain(b);
    endcase
    if (fin) begin
      if (esc_mode == MODE_HEX) flush_unicode();
      clear_unicode();
    end
    n = decoded_q.size();
    if (n == 0) begin
      if (fin) expected_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    end else begin
      for (int k = 0; k < n; k++)
        expected_q.push_back('{decoded_q[k], 1'b1, k == n - 1, (k == n - 1) && fin});
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.final_byte <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_unescape(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // The sender stops and waits until every expected result has been seen.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return CHR_ZERO + {4'd0, nib};
    if ($urandom_range(0, 1)) return CHR_UPPER + {4'd0, nib} - 8'd10;
    return CHR_LOWER + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] edges [10] = '{16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h07FF,
                                16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF, 16'h7FFF};
    case ($urandom_range(0, 3))
      0: return edges[$urandom_range(0, 9)];
      1: return 16'($urandom_range(0, 16'h007F));
      2: return 16'($urandom_range(16'h0080, 16'h07FF));
      default: return 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  function automatic void push_hex_digits(logic [15:0] cp, int count);
    for (int i = 0; i < count; i++) text_q.push_back(hex_char(cp[15 - 4 * i -: 4]));
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (hex_value(b) >= 0) b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  function automatic void add_random_unit();
    logic [7:0] simple [8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_BSLASH, CHR_QUOTE, CHR_SLASH};
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(1, 255));
        while (b == CH_BSLASH) b = 8'($urandom_range(1, 255));
        text_q.push_back(b);
      end
      4, 5: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(simple[$urandom_range(0, 7)]);
      end
      6: begin
        b = 8'($urandom_range(1, 255));
        while (b == CH_U) b = 8'($urandom_range(1, 255));
        text_q.push_back(CH_BSLASH);
        text_q.push_back(b);
      end
      7, 8: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        push_hex_digits(pick_code_point(), 4);
      end
      default: begin
        // Broken \u: too few digits followed by something that is not a digit.
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        push_hex_digits(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 3)));
        text_q.push_back(pick_non_hex());
      end
    endcase
  endfunction

  function automatic void build_random_text();
    text_q.delete();
    repeat ($urandom_range(1, 8)) add_random_unit();
    case ($urandom_range(0, 9))
      0: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        push_hex_digits(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 3)));
      end
      1: text_q.push_back(CH_BSLASH);
      default: ;
    endcase
  endfunction

  task automatic run_random_strings(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_random_text();
      send_text_q();
    end
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_simple_escapes();
    send_text("\\b\\f\\n\\r\\t\\\\\\z");
    drain();
  endtask

  task automatic test_broken_unicode();
    // Three digits, then a backslash that is scanned again and opens a new escape.
    send_text("\\u12a\\n");
    send_text("\\u7");
    drain();
  endtask

  task automatic test_trailing_backslash();
    send_text("\\");
    drain();
  endtask

  task automatic test_output_stall();
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    rx_hold_len = 300;
    run_random_strings(30);
    drain();
  endtask

  task automatic test_random_with_gaps();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_random_strings(55);
    drain();
    run_random_strings(55);
  endtask

  task automatic test_random_streaming();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random_strings(30);
    drain();
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual byte %0h valid %0b %s",
                 $time, out_if.out_byte, out_if.byte_valid,
                 $sformatf("last %0b done %0b", out_if.run_last, out_if.string_done));
        errors++;
      end else begin
        head_r = expected_q.pop_front();
        check_field("out_byte", head_r.out_byte, out_if.out_byte);
        check_field("byte_valid", 8'(head_r.byte_valid), 8'(out_if.byte_valid));
        check_field("run_last", 8'(head_r.run_last), 8'(out_if.run_last));
        check_field("string_done", 8'(head_r.string_done), 8'(out_if.string_done));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_left;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        hold_left   = rx_hold_len;
        rx_hold_len = 0;
        out_if.ready <= 1'b0;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        out_if.ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL json_string_unescape");
      $finish;
    end
  end

  initial begin
    clear_unicode();
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= 8'h00;
    in_if.final_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_byte_extremes();
    test_simple_escapes();
    test_broken_unicode();
    test_trailing_backslash();
    test_output_stall();
    test_random_with_gaps();
    test_random_streaming();
    if (errors == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/jsu_pkg.sv
sv/jsu_in_if.sv
sv/jsu_out_if.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape.sv
tb/sv/json_string_unescape_tb.sv
